>>> sv/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg - shared constants and types for the trial division prime filter
// Widths of the candidate, the magnitude datapath and the prime counter.
// ----------------------------------------------------------------------------
package tdpf_pkg;

  // Candidate width, two's complement
  localparam int VALUE_WIDTH = 32;
  // Magnitude of a non-negative candidate
  localparam int MAG_W       = VALUE_WIDTH - 1;
  // Prime ordinal counter
  localparam int CNT_W       = 32;
  // Divider step counter, counts MAG_W-1 down to 0
  localparam int STEP_W      = $clog2(MAG_W);

  typedef logic [MAG_W-1:0] mag_t;

  // Result of one division
  typedef struct packed {
    logic done;
    mag_t quotient;
    mag_t remainder;
  } div_res_t;

endpackage

>>> sv/trial_division_prime_filter_top.sv
// Per trial divisor the sequencer passes S_START, waits in S_WAIT while the
// serial divider steps, then decides on done; a candidate runs divisors until
// one divides it or the divisor passes the quotient.
// Requests: one at a time; a new one is taken only back in S_IDLE.
// Negative, zero and one are dropped in the accept cycle.
// Reset (rst, synchronous): sequencer idle, result empty, prime counter zero.
// ----------------------------------------------------------------------------
// trial_division_prime_filter_top - trial division prime filter
// Tests each signed candidate by dividing by 2, 3, 4, ... while the divisor
// does not exceed the quotient; primes leave with their running ordinal.
// ----------------------------------------------------------------------------
module trial_division_prime_filter_top (
  input  logic                              clk,
  input  logic                              rst,
  // candidate request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tdpf_pkg::VALUE_WIDTH-1:0] candidate,
  // prime result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdpf_pkg::MAG_W-1:0]        prime_value,
  output logic [tdpf_pkg::CNT_W-1:0]        prime_ordinal
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t                      state;
  tdpf_pkg::mag_t              num;       // candidate magnitude under test
  tdpf_pkg::mag_t              dvs;       // current trial divisor
  logic [tdpf_pkg::CNT_W-1:0]  primes_found;
  logic                        div_start;
  tdpf_pkg::div_res_t          div_res;
  logic                        in_acc;
  logic                        worth_testing;
  logic                        out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  // sign clear and magnitude at least two
  assign worth_testing = !candidate[tdpf_pkg::VALUE_WIDTH-1]
                      && (candidate[tdpf_pkg::MAG_W-1:1] != '0);
  assign div_start = (state == S_START);
  // output register can take a new result this cycle
  assign out_free  = !out_valid || out_ready;

  tdpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (dvs),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      primes_found <= '0;
    end else begin
      // result taken; S_EMIT refills the register itself
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && worth_testing) begin
            num   <= candidate[tdpf_pkg::MAG_W-1:0];
            dvs   <= tdpf_pkg::MAG_W'(2);
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            if (div_res.quotient < dvs) begin
              // divisor passed the square root: no factor found
              state <= S_EMIT;
            end else if (div_res.remainder == '0) begin
              state <= S_IDLE;        // composite, dropped
            end else begin
              dvs   <= dvs + 1'b1;
              state <= S_START;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            prime_value   <= num;
            prime_ordinal <= primes_found;
            primes_found  <= primes_found + 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/tdpf_div.sv
// ----------------------------------------------------------------------------
// tdpf_div - restoring serial divider
// One quotient bit per cycle; done pulses with quotient and remainder valid.
// ----------------------------------------------------------------------------
module tdpf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tdpf_pkg::mag_t      dividend,
  input  tdpf_pkg::mag_t      divisor,
  output tdpf_pkg::div_res_t  res
);

  logic                       busy;
  logic [tdpf_pkg::STEP_W-1:0] step;
  tdpf_pkg::mag_t             rem;
  tdpf_pkg::mag_t             quo;
  tdpf_pkg::mag_t             dsr;
  logic                       done;

  logic [tdpf_pkg::MAG_W:0]   shifted;
  logic [tdpf_pkg::MAG_W:0]   diff;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem, quo[tdpf_pkg::MAG_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= tdpf_pkg::STEP_W'(tdpf_pkg::MAG_W - 1);
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!diff[tdpf_pkg::MAG_W]) begin
          rem <= diff[tdpf_pkg::MAG_W-1:0];
          quo <= {quo[tdpf_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem <= shifted[tdpf_pkg::MAG_W-1:0];
          quo <= {quo[tdpf_pkg::MAG_W-2:0], 1'b0};
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

>>> sv/tdpf_check.sv
// ----------------------------------------------------------------------------
// tdpf_check - port level checks for the prime filter
// Bound to the top level; watches the handshakes and result values.
// ----------------------------------------------------------------------------
module tdpf_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [tdpf_pkg::VALUE_WIDTH-1:0]  candidate,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tdpf_pkg::MAG_W-1:0]        prime_value,
  input logic [tdpf_pkg::CNT_W-1:0]        prime_ordinal
);

  // ordinal the next result has to carry
  logic [tdpf_pkg::CNT_W-1:0] next_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ord <= '0;
    end else if (out_valid && out_ready) begin
      next_ord <= prime_ordinal + 1'b1;
    end
  end

  // after reset the block is empty and takes requests
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // a testable candidate keeps the block busy for the next cycle at least
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !candidate[tdpf_pkg::VALUE_WIDTH-1]
     && (candidate[tdpf_pkg::MAG_W-1:1] != '0)) |=> !in_ready)
    else $error("request taken while a test runs");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(prime_value)
                                  && $stable(prime_ordinal))
    else $error("stalled result changed");

  // a reported prime is at least two
  a_prime_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prime_value[tdpf_pkg::MAG_W-1:1] != '0))
    else $error("result below two");

  // consecutive results carry consecutive ordinals, from zero after reset
  a_ordinal_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prime_ordinal == next_ord)
    else $error("ordinal out of step");

endmodule

bind trial_division_prime_filter_top tdpf_check u_tdpf_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .candidate     (candidate),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .prime_value   (prime_value),
  .prime_ordinal (prime_ordinal)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - trial division prime filter regression
// Feeds signed candidates through the request channel and checks that each
// prime leaves with the right value and running ordinal, in arrival order,
// against a behavioural predictor kept inside this bench.
// ----------------------------------------------------------------------------
module testbench;

  // Watchdog: the slowest legal run is dominated by 2^31-1, the costliest
  // candidate, so allow a wide margin on top of that.
  localparam int unsigned CYCLE_LIMIT  = 12_000_000;
  // Longest work that can still be in flight once the last prime is out:
  // a dropped random candidate of at most 300 trial divisors.
  localparam int unsigned DRAIN_CYCLES = 12_000;
  // Random part: requests sent, cap on divisors for a wide random candidate
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned MAX_TRIALS   = 300;
  // Receiver hold-off used to back the block up into its request side
  localparam int unsigned HOLD_CYCLES  = 20_000;

  // Outcome of trial division on one candidate
  typedef struct packed {
    logic        prime;
    logic [31:0] trials;
  } trial_t;

  // One prime as it should leave the block
  typedef struct packed {
    tdpf_pkg::mag_t             value;
    logic [tdpf_pkg::CNT_W-1:0] ordinal;
  } prime_rec_t;

  // Directed stimulus row; where known is set the expected outcome is typed
  // into the table, otherwise the predictor works it out
  typedef struct packed {
    logic [tdpf_pkg::VALUE_WIDTH-1:0] cand;
    logic                             known;
    logic                             yields;
    tdpf_pkg::mag_t                   value;
    logic [tdpf_pkg::CNT_W-1:0]       ordinal;
  } cand_row_t;

  logic                                    clk       = 1'b0;
  logic                                    rst       = 1'b1;
  logic                                    in_valid  = 1'b0;
  logic                                    in_ready;
  logic signed [tdpf_pkg::VALUE_WIDTH-1:0] candidate = '0;
  logic                                    out_valid;
  logic                                    out_ready = 1'b0;
  tdpf_pkg::mag_t                          prime_value;
  logic [tdpf_pkg::CNT_W-1:0]              prime_ordinal;

  // Primes still owed by the block, oldest first
  prime_rec_t                 pending_primes[$];
  // Predictor copy of the block's prime counter
  logic [tdpf_pkg::CNT_W-1:0] prime_tally = '0;
  int unsigned                errors      = 0;
  int unsigned                counted     = 0;
  int unsigned                cycle_count = 0;
  // calm: last stretch, no idling on either side; hold_long: long back-pressure
  logic                       calm        = 1'b0;
  logic                       hold_long   = 1'b0;
  int unsigned                sink_gap    = 0;

  trial_division_prime_filter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .candidate     (candidate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .prime_value   (prime_value),
    .prime_ordinal (prime_ordinal)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Trial division as the block does it: divisors 2, 3, 4, ... while the
  // divisor does not exceed the quotient. Anything below 2, negatives
  // included, is not prime. trials also serves as a cost estimate.
  function automatic trial_t trial_divide(
      input logic signed [tdpf_pkg::VALUE_WIDTH-1:0] v);
    trial_t         r;
    tdpf_pkg::mag_t n;
    logic [31:0]    d;
    r.prime  = 1'b0;
    r.trials = '0;
    if (v < 2) return r;
    n = v[tdpf_pkg::MAG_W-1:0];
    r.prime = 1'b1;
    for (d = 32'd2; d <= n / d; d++) begin
      r.trials++;
      if (n % d == 0) begin
        r.prime = 1'b0;
        break;
      end
    end
    return r;
  endfunction

  function automatic cand_row_t cand_row(
      input logic [tdpf_pkg::VALUE_WIDTH-1:0] c,
      input logic k, input logic y,
      input tdpf_pkg::mag_t pv, input logic [tdpf_pkg::CNT_W-1:0] po);
    cand_row_t r;
    r.cand    = c;
    r.known   = k;
    r.yields  = y;
    r.value   = pv;
    r.ordinal = po;
    return r;
  endfunction

  // Offer one request and log what it should produce once accepted.
  // Random gaps before the request unless in the calm stretch.
  task automatic send_candidate(input cand_row_t r);
    trial_t t;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= r.cand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.known) begin
      if (r.yields) begin
        pending_primes.push_back({r.value, r.ordinal});
        prime_tally++;
      end
    end else begin
      t = trial_divide(r.cand);
      if (t.prime) begin
        pending_primes.push_back({r.cand[tdpf_pkg::MAG_W-1:0], prime_tally});
        prime_tally++;
      end
    end
  endtask

  // Receiver: random stall bursts, a long hold-off when asked, none when calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap  <= 0;
    end else if (hold_long) begin
      out_ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap  <= sink_gap - 1;
      out_ready <= (sink_gap == 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap  <= $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long hold-off, counted here: once the random part is under way the
  // receiver stops taking results while requests keep coming, so the result
  // slot fills and the block has to push back on its request side.
  initial begin : long_hold
    wait (counted >= 10);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  // Result checker: every accepted result against the oldest owed prime
  always @(posedge clk) begin : result_check
    prime_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_primes.size() == 0) begin
        errors++;
        $error("unexpected result: prime_value %0d prime_ordinal %0d",
               prime_value, prime_ordinal);
      end else begin
        want = pending_primes.pop_front();
        if (prime_value !== want.value) begin
          errors++;
          $error("prime_value: expected %0d, got %0d", want.value, prime_value);
        end
        if (prime_ordinal !== want.ordinal) begin
          errors++;
          $error("prime_ordinal: expected %0d, got %0d", want.ordinal, prime_ordinal);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    cand_row_t                               rows[20];
    logic signed [tdpf_pkg::VALUE_WIDTH-1:0] v;
    trial_t                                  t;

    // Directed table. Typed-in outcomes: first primes after reset, the
    // field extremes, and the values that are never prime (negatives, zero,
    // one). Counter wrap needs 2^32 primes and is out of reach here.
    rows[0]  = cand_row(32'd2,         1'b1, 1'b1, 31'd2, 32'd0); // smallest prime
    rows[1]  = cand_row(32'd3,         1'b1, 1'b1, 31'd3, 32'd1);
    rows[2]  = cand_row(32'd0,         1'b1, 1'b0, 31'd0, 32'd0); // zero
    rows[3]  = cand_row(32'd1,         1'b1, 1'b0, 31'd0, 32'd0); // one
    rows[4]  = cand_row(32'hFFFF_FFFF, 1'b1, 1'b0, 31'd0, 32'd0); // minus one
    rows[5]  = cand_row(32'h8000_0000, 1'b1, 1'b0, 31'd0, 32'd0); // most negative
    rows[6]  = cand_row(32'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFF, 32'd2); // 2^31-1
    rows[7]  = cand_row(32'h7FFF_FFFE, 1'b1, 1'b0, 31'd0, 32'd0); // even extreme
    rows[8]  = cand_row(32'hFFFF_FFF9, 1'b1, 1'b0, 31'd0, 32'd0); // minus seven
    // Predictor-checked rows: square boundaries, assorted primes, wide composites
    rows[9]  = cand_row(32'd4,         1'b0, 1'b0, 31'd0, 32'd0);
    rows[10] = cand_row(32'd9,         1'b0, 1'b0, 31'd0, 32'd0);
    rows[11] = cand_row(32'd25,        1'b0, 1'b0, 31'd0, 32'd0);
    rows[12] = cand_row(32'd63001,     1'b0, 1'b0, 31'd0, 32'd0); // 251 squared
    rows[13] = cand_row(32'd97,        1'b0, 1'b0, 31'd0, 32'd0);
    rows[14] = cand_row(32'd65537,     1'b0, 1'b0, 31'd0, 32'd0);
    rows[15] = cand_row(32'd131071,    1'b0, 1'b0, 31'd0, 32'd0);
    rows[16] = cand_row(32'h3FFF_FFFF, 1'b0, 1'b0, 31'd0, 32'd0);
    rows[17] = cand_row(32'h7FFF_FFFD, 1'b0, 1'b0, 31'd0, 32'd0);
    rows[18] = cand_row(32'd5,         1'b0, 1'b0, 31'd0, 32'd0);
    rows[19] = cand_row(32'd7919,      1'b0, 1'b0, 31'd0, 32'd0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_candidate(rows[i]);

    // Random part: mostly cheap primes and cheap composites, plus requests
    // the block just drops. Wide 31-bit values are kept to candidates with
    // a small factor so the run stays short.
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do begin
            v = $urandom_range(2, 50000);
            t = trial_divide(v);
          end while (!t.prime);
        end
        4: v = $urandom() | 32'h8000_0000;
        5: v = $urandom_range(0, 1);
        6, 7: begin
          do begin
            v = $urandom() & 32'h7FFF_FFFF;
            t = trial_divide(v);
          end while (t.trials > MAX_TRIALS);
        end
        default: v = $urandom_range(0, 65535);
      endcase
      send_candidate(cand_row(v, 1'b0, 1'b0, 31'd0, 32'd0));
      counted++;
      if (counted >= RANDOM_ITEMS - 15) calm <= 1'b1;
    end
    in_valid <= 1'b0;

    while (pending_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
